// File: src/ectv_pkg.sv
// ----------------------------------------------------------------------------
// Encoder tick counter package
// Shared widths, reset values, operation codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ectv_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned SCALE_W         = 24;
  localparam int unsigned TIME_W          = 64;
  localparam int unsigned OUT_W           = 32;
  localparam int unsigned FUNC_W          = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1292526);

  // Operation codes of an input beat. The unused code reads the count.
  localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_VEL  = 2'd2;

  localparam logic [OUT_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] VEL_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: src/ectv_if.sv
// ----------------------------------------------------------------------------
// Encoder tick counter channels
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ectv_in_if import ectv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              b_level;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, func, b_level, time_us, input ready);
  modport sink   (input valid, func, b_level, time_us, output ready);
endinterface

interface ectv_out_if import ectv_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] tick_count;
  logic signed [OUT_W-1:0] velocity;
  logic                    velocity_fresh;

  modport source (output valid, tick_count, velocity, velocity_fresh, input ready);
  modport sink   (input valid, tick_count, velocity, velocity_fresh, output ready);
endinterface

`default_nettype wire

// File: src/ectv_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ectv_mul import ectv_pkg::*; #(
  parameter int unsigned CW = COUNT_WIDTH_DEF,
  parameter int unsigned SW = SCALE_W
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [CW-1:0]  mcand_i,
  input  wire logic [SW-1:0]  mplier_i,
  output logic                done_o,
  output logic [CW+SW-1:0]    product_o
);

  localparam int unsigned CNT_W = $clog2(SW + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CW-1:0]     mcand_q;
  logic [CW+SW-1:0]  p_q, p_d;
  logic [CW:0]       sum;
  logic              last;

  // The upper part accumulates while the multiplier bits shift out below.
  always_comb begin
    sum = {1'b0, p_q[CW+SW-1:SW]} + (p_q[0] ? {1'b0, mcand_q} : '0);
    p_d = {sum, p_q[SW-1:1]};
  end

  assign last = (cnt_q == CNT_W'(SW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      p_q     <= {{CW{1'b0}}, mplier_i};
    end else if (busy_q && !last) begin
      p_q <= p_d;
    end
  end

  assign done_o    = busy_q && last;
  assign product_o = p_q;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q || start_i)
    else $error("multiplier stays busy after done");

endmodule

`default_nettype wire

// File: src/ectv_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ectv_div import ectv_pkg::*; #(
  parameter int unsigned NW = COUNT_WIDTH_DEF + SCALE_W,
  parameter int unsigned DW = TIME_W,
  parameter int unsigned QW = OUT_W
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [NW-1:0]  dividend_i,
  input  wire logic [DW-1:0]  divisor_i,
  output logic                done_o,
  output logic [QW-1:0]       quot_o,
  output logic                ovf_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NW-1:0]     dvd_q;
  logic [DW-1:0]     rem_q, rem_d;
  logic [QW-1:0]     q_q;
  logic              ovf_q;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              ge;
  logic              last;

  always_comb begin
    trial = {rem_q, dvd_q[NW-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
    // The remainder stays below the divisor, so it fits in DW bits.
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  assign last = (cnt_q == CNT_W'(NW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Quotient bits shifted past the top mark the result as out of range.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q && !last) begin
      dvd_q <= {dvd_q[NW-2:0], 1'b0};
      rem_q <= rem_d;
      q_q   <= {q_q[QW-2:0], ge};
      ovf_q <= ovf_q | q_q[QW-1];
    end
  end

  assign done_o = busy_q && last;
  assign quot_o = q_q;
  assign ovf_o  = ovf_q;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q || start_i)
    else $error("divider stays busy after done");

endmodule

`default_nettype wire

// File: src/encoder_tick_counter_velocity_top.sv
// ----------------------------------------------------------------------------
// Encoder tick counter with velocity estimate
// X1 quadrature tick counter; velocity samples give scaled ticks per interval.
// ----------------------------------------------------------------------------
// Edge and count-read beats, and velocity beats that do not compute: result
// registered in the cycle after acceptance. Primed velocity beats with a nonzero
// interval pass through the serial multiplier, the serial divider, the velocity
// register and the result register; one beat is worked on at a time.
// Asynchronous active-low reset clears the counters, the sample state and the
// primed flag, and loads the scale register with its default.
`default_nettype none

module encoder_tick_counter_velocity_top import ectv_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [SCALE_W-1:0] cfg_wdata_i,
  ectv_in_if.sink                 in_i,
  ectv_out_if.source              out_o
);

  localparam int unsigned PW = COUNT_WIDTH + SCALE_W;

  state_e state_q, state_d;

  logic [SCALE_W-1:0]     scale_q;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] count_smp_q;
  logic [TIME_W-1:0]      time_smp_q;
  logic                   primed_q;
  logic [TIME_W-1:0]      dt_q;
  logic                   neg_q;
  logic [OUT_W-1:0]       vel_q;

  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_tick_q;
  logic [OUT_W-1:0]       out_vel_q;
  logic                   out_fresh_q;

  logic                   in_acc;
  logic                   slot_free;
  logic                   is_vel;
  logic [TIME_W-1:0]      dt;
  logic [COUNT_WIDTH-1:0] delta;
  logic [COUNT_WIDTH-1:0] mag;
  logic                   compute;
  logic                   mul_start, div_start, done_load, imm_load;
  logic                   mul_done, div_done;
  logic [PW-1:0]          product;
  logic [OUT_W-1:0]       quot;
  logic                   div_ovf;
  logic                   sat;
  logic [OUT_W-1:0]       vel_res;

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_acc    = in_i.valid && in_i.ready;
  assign is_vel    = (in_i.func == FUNC_VEL);
  assign dt        = in_i.time_us - time_smp_q;
  assign delta     = count_q - count_smp_q;
  assign mag       = delta[COUNT_WIDTH-1] ? -delta : delta;
  // Only a primed sample over a nonzero interval runs the arithmetic.
  assign compute   = is_vel && primed_q && (dt != '0);

  always_comb begin
    unique case (in_i.func)
      FUNC_EDGE: count_d = in_i.b_level ? count_q + 1'b1 : count_q - 1'b1;
      default:   count_d = count_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && compute) state_d = ST_MUL;
      ST_MUL:  if (mul_done) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_i.ready = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    done_load  = 1'b0;
    imm_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = slot_free;
        mul_start  = in_acc && compute;
        imm_load   = in_acc && !compute;
      end
      ST_MUL:  div_start = mul_done;
      ST_DIV:  ;
      ST_DONE: done_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      count_smp_q <= '0;
      time_smp_q  <= '0;
      primed_q    <= 1'b0;
    end else if (in_acc) begin
      count_q <= count_d;
      if (is_vel && (!primed_q || dt != '0)) begin
        primed_q    <= 1'b1;
        count_smp_q <= count_q;
        time_smp_q  <= in_i.time_us;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      dt_q  <= dt;
      neg_q <= delta[COUNT_WIDTH-1];
    end
  end

  ectv_mul #(
    .CW (COUNT_WIDTH),
    .SW (SCALE_W)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mag),
    .mplier_i  (scale_q),
    .done_o    (mul_done),
    .product_o (product)
  );

  ectv_div #(
    .NW (PW),
    .DW (TIME_W),
    .QW (OUT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .ovf_o      (div_ovf)
  );

  // A quotient of 2^31 or more saturates in either direction.
  always_comb begin
    sat = div_ovf || quot[OUT_W-1];
    if (neg_q) begin
      vel_res = sat ? VEL_MIN : -quot;
    end else begin
      vel_res = sat ? VEL_MAX : quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      vel_q <= vel_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (imm_load || done_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (imm_load) begin
      out_tick_q  <= OUT_W'(signed'(count_d));
      out_vel_q   <= '0;
      out_fresh_q <= 1'b0;
    end else if (done_load) begin
      out_tick_q  <= OUT_W'(signed'(count_q));
      out_vel_q   <= vel_q;
      out_fresh_q <= 1'b1;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.tick_count     = signed'(out_tick_q);
  assign out_o.velocity       = signed'(out_vel_q);
  assign out_o.velocity_fresh = out_fresh_q;

  a_busy_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input taken while a velocity computation is running");

  a_mul_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside its phase");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its phase");

  a_vel_primes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_vel) |=> primed_q)
    else $error("velocity sample did not prime the estimator");

  a_fresh_primed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fresh_q) |-> primed_q)
    else $error("fresh velocity without a prior sample");

endmodule

`default_nettype wire

// File: tb/sv/ectv_reading_checker.sv
// ----------------------------------------------------------------------------
// Encoder tick counter result checker
// Watches the input, result and scale-register ports, keeps its own copy of
// the tick counter and velocity sampler, and compares every result beat with
// the oldest predicted reading, field by field.
// ----------------------------------------------------------------------------
module ectv_reading_checker import ectv_pkg::*; #(
  parameter int unsigned COUNT_W = COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SCALE_W-1:0] cfg_wdata_i,
  ectv_in_if                 in_mon,
  ectv_out_if                out_mon,
  output int unsigned        mismatches_o,
  output int unsigned        readings_o,
  output int unsigned        pending_o,
  output int unsigned        fresh_o,
  output int unsigned        saturated_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OUT_W-1:0] tick_count;
    logic signed [OUT_W-1:0] velocity;
    logic                    velocity_fresh;
  } reading_t;

  logic [SCALE_W-1:0] scale           = SCALE_RESET;
  logic [COUNT_W-1:0] count_now       = '0;
  logic [COUNT_W-1:0] count_at_sample = '0;
  logic [TIME_W-1:0]  time_at_sample  = '0;
  logic               primed          = 1'b0;

  reading_t    expected_readings[$];
  int unsigned n_mismatch  = 0;
  int unsigned n_readings  = 0;
  int unsigned n_fresh     = 0;
  int unsigned n_saturated = 0;

  task automatic report_mismatch(input string msg);
    $display("%t ERROR %s", $realtime, msg);
    n_mismatch++;
  endtask

  // Ticks since the last sample times the scale, over the elapsed time,
  // truncated toward zero and clamped to the signed 32-bit range.
  function automatic logic [OUT_W-1:0] scaled_velocity(input logic [COUNT_W-1:0] delta,
                                                       input logic [TIME_W-1:0]  dt,
                                                       input logic [SCALE_W-1:0] scl);
    logic               neg;
    logic [COUNT_W-1:0] mag;
    logic [127:0]       prod;
    logic [127:0]       quo;
    neg  = delta[COUNT_W-1];
    mag  = neg ? -delta : delta;
    prod = 128'(mag) * 128'(scl);
    quo  = prod / 128'(dt);
    if (neg) begin
      return (quo >= 128'h8000_0000) ? VEL_MIN : -quo[OUT_W-1:0];
    end
    return (quo >= 128'h8000_0000) ? VEL_MAX : quo[OUT_W-1:0];
  endfunction

  task automatic apply_encoder_beat(input  logic [FUNC_W-1:0] op,
                                    input  logic              b,
                                    input  logic [TIME_W-1:0] now,
                                    output reading_t          r);
    logic [TIME_W-1:0] dt;
    r.velocity       = '0;
    r.velocity_fresh = 1'b0;
    dt               = now - time_at_sample;
    case (op)
      FUNC_EDGE: begin
        count_now = b ? count_now + 1'b1 : count_now - 1'b1;
      end
      FUNC_VEL: begin
        if (!primed) begin
          primed          = 1'b1;
          time_at_sample  = now;
          count_at_sample = count_now;
        end else if (dt != '0) begin
          r.velocity       = scaled_velocity(count_now - count_at_sample, dt, scale);
          r.velocity_fresh = 1'b1;
          count_at_sample  = count_now;
          time_at_sample   = now;
        end
      end
      default: begin
        // A count read, and the unused code, change nothing.
      end
    endcase
    r.tick_count = OUT_W'(signed'(count_now));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    reading_t got;
    if (!rst_ni) begin
      scale           = SCALE_RESET;
      count_now       = '0;
      count_at_sample = '0;
      time_at_sample  = '0;
      primed          = 1'b0;
      expected_readings.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        n_readings++;
        got.tick_count     = out_mon.tick_count;
        got.velocity       = out_mon.velocity;
        got.velocity_fresh = out_mon.velocity_fresh;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: count %0d velocity %0d",
                                    got.tick_count, got.velocity));
        end else begin
          want = expected_readings.pop_front();
          if (got.tick_count !== want.tick_count) begin
            report_mismatch($sformatf("tick_count %0d, expected %0d",
                                      got.tick_count, want.tick_count));
          end
          if (got.velocity !== want.velocity) begin
            report_mismatch($sformatf("velocity %0d, expected %0d",
                                      got.velocity, want.velocity));
          end
          if (got.velocity_fresh !== want.velocity_fresh) begin
            report_mismatch($sformatf("velocity_fresh %b, expected %b",
                                      got.velocity_fresh, want.velocity_fresh));
          end
          if (want.velocity_fresh) begin
            n_fresh++;
            if (want.velocity == VEL_MAX || want.velocity == VEL_MIN) begin
              n_saturated++;
            end
          end
        end
      end
      if (cfg_we_i) begin
        scale = cfg_wdata_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_encoder_beat(in_mon.func, in_mon.b_level, in_mon.time_us, want);
        expected_readings.push_back(want);
      end
    end
    mismatches_o <= n_mismatch;
    readings_o   <= n_readings;
    pending_o    <= expected_readings.size();
    fresh_o      <= n_fresh;
    saturated_o  <= n_saturated;
  end

endmodule

// File: tb/sv/encoder_tick_counter_velocity_top_test.sv
// ----------------------------------------------------------------------------
// Encoder tick counter testbench
// Drives edges, count reads and velocity samples through the input channel,
// moves the scale register between phases, and stalls both channels at
// random. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module encoder_tick_counter_velocity_top_test;
  import ectv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [SCALE_W-1:0] cfg_wdata_i;

  ectv_in_if  in_if ();
  ectv_out_if out_if ();

  int unsigned mismatches;
  int unsigned readings;
  int unsigned pending;
  int unsigned fresh;
  int unsigned saturated;

  int unsigned       beats_sent     = 0;
  int unsigned       scale_settings = 1;
  bit                idle_en        = 1'b1;
  logic [TIME_W-1:0] sample_clock   = '0;

  encoder_tick_counter_velocity_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  ectv_reading_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .mismatches_o (mismatches),
    .readings_o   (readings),
    .pending_o    (pending),
    .fresh_o      (fresh),
    .saturated_o  (saturated)
  );

  always #5 clk_i = ~clk_i;

  // Result side: accept by default, with short random stalls.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic b,
                           input logic [TIME_W-1:0] t);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.b_level <= b;
    in_if.time_us <= t;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    beats_sent++;
  endtask

  // The scale register may only move while nothing is in flight.
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    in_if.valid <= 1'b0;
    while (readings != beats_sent) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scale_settings++;
  endtask

  function automatic logic [TIME_W-1:0] next_sample_time(input bit short_step);
    int unsigned pick;
    pick = $urandom_range(0, 31);
    if (short_step) begin
      sample_clock = sample_clock + 1'b1;
    end else if (pick < 2) begin
      // Same time as the last sample: a zero interval.
    end else if (pick == 2) begin
      sample_clock = {$urandom, $urandom};
    end else if (pick == 3) begin
      sample_clock = sample_clock - TIME_W'($urandom_range(1, 1000));
    end else if (pick < 6) begin
      sample_clock = sample_clock + ({$urandom, $urandom} >> $urandom_range(0, 63));
    end else begin
      sample_clock = sample_clock + TIME_W'($urandom_range(1, 5000));
    end
    return sample_clock;
  endfunction

  // Runs of edges, mostly in one direction with a few reads mixed in, each
  // closed by a velocity sample. A long run with a one-microsecond interval
  // pushes the velocity into saturation at large scales.
  task automatic run_phase(input int unsigned beats, input int unsigned long_odds);
    int unsigned stop_at;
    int unsigned n;
    bit          up;
    bit          long_run;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      long_run = ($urandom_range(0, long_odds) == 0);
      n        = long_run ? $urandom_range(200, 300) : $urandom_range(0, 12);
      up       = 1'($urandom_range(0, 1));
      repeat (n) begin
        if (!long_run && $urandom_range(0, 5) == 0) begin
          send_beat(FUNC_READ, 1'($urandom_range(0, 1)), {$urandom, $urandom});
        end
        send_beat(FUNC_EDGE, (long_run || $urandom_range(0, 5) != 0) ? up : !up,
                  {$urandom, $urandom});
      end
      send_beat(FUNC_VEL, 1'($urandom_range(0, 1)), next_sample_time(long_run));
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_if.valid   <= 1'b0;
    in_if.func    <= FUNC_EDGE;
    in_if.b_level <= 1'b0;
    in_if.time_us <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset scale: reads before priming, a first sample
    // at time zero, zero intervals, both directions, time running backwards,
    // the top of the time range and the wrap back to zero.
    send_beat(FUNC_READ, 1'b1, '0);
    send_beat(FUNC_EDGE, 1'b0, '1);
    send_beat(FUNC_VEL, 1'b0, 64'd0);
    send_beat(FUNC_VEL, 1'b1, 64'd0);
    repeat (3) send_beat(FUNC_EDGE, 1'b1, '0);
    send_beat(FUNC_READ, 1'b0, '1);
    send_beat(FUNC_VEL, 1'b0, 64'd1000);
    send_beat(FUNC_VEL, 1'b0, 64'd1000);
    repeat (3) send_beat(FUNC_EDGE, 1'b0, '1);
    send_beat(FUNC_VEL, 1'b1, 64'd1001);
    send_beat(FUNC_VEL, 1'b0, 64'd5);
    send_beat(FUNC_EDGE, 1'b1, '0);
    send_beat(FUNC_VEL, 1'b0, '1);
    send_beat(FUNC_EDGE, 1'b1, '0);
    send_beat(FUNC_VEL, 1'b1, 64'd0);
    send_beat(FUNC_VEL, 1'b0, 64'h8000_0000_0000_0000);
    send_beat(FUNC_READ, 1'b1, '0);
    sample_clock = 64'h8000_0000_0000_0000;

    write_scale('1);
    run_phase(500, 2);
    write_scale(SCALE_W'(1));
    run_phase(200, 39);
    write_scale(SCALE_W'($urandom_range(1, 24'hFF_FFFF)));
    run_phase(300, 39);
    write_scale(SCALE_RESET);
    run_phase(300, 39);
    write_scale(SCALE_W'($urandom_range(1, 24'hFF_FFFF)));
    idle_en = 1'b0;
    run_phase(200, 39);

    in_if.valid <= 1'b0;
    while (readings != beats_sent) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d beats over %0d scale settings; %0d result beats checked.",
             beats_sent, scale_settings, readings);
    $display("%0d fresh velocity readings, %0d of them clamped at the 32-bit limits.",
             fresh, saturated);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timeout: %0d beats sent, %0d results seen", beats_sent, readings);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
src/ectv_pkg.sv
src/ectv_if.sv
src/ectv_mul.sv
src/ectv_div.sv
src/encoder_tick_counter_velocity_top.sv
tb/sv/ectv_reading_checker.sv
tb/sv/encoder_tick_counter_velocity_top_test.sv
